// ===== hw/rtl/rgb_to_hsv_converter_unit_macros.svh =====
// Assertion macros shared by the RGB to HSV converter RTL.
// Depends on nothing; included by the top level only.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RGB2HSV_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rgb2hsv: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RGB2HSV_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rgb2hsv: next-cycle check failed");

`endif

// ===== hw/rtl/rgb2hsv_pkg.sv =====
// Shared constants and stage types of the RGB to HSV converter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rgb2hsv_pkg;

   // Field widths and fixed-point scaling.
   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 4;
   localparam int HUE_W         = 13;
   localparam int SAT_W         = 8;
   localparam int VAL_W         = CHANNEL_BITS;

   localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;
   localparam int HUE_SIXTY     = 60 << HUE_FRAC_BITS;
   localparam int HUE_FULL      = 360 << HUE_FRAC_BITS;
   localparam int HUE_STEP      = 2 * HUE_SIXTY;
   localparam int SAT_STEP      = 2 * CHAN_MAX;

   // Sector position runs up to seven times the channel difference.
   localparam int POS_W         = CHANNEL_BITS + 3;

   // Divider geometry: one quotient bit per cell.
   localparam int QUO_W         = HUE_W;
   localparam int DIV_W         = CHANNEL_BITS + 1;
   localparam int NUM_W         = QUO_W + DIV_W;
   localparam int CELL_COUNT    = QUO_W;

   // One long division in flight: partial remainder, numerator bits still
   // to be brought down (quotient bits fill in from the bottom), divisor.
   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] bits;
      logic [DIV_W-1:0] div;
   } rgb2hsv_div_type;

   // Everything that travels along the chain with one pixel.
   typedef struct packed {
      rgb2hsv_div_type  hue;
      rgb2hsv_div_type  sat;
      logic             hue_zero;
      logic             sat_zero;
      logic [VAL_W-1:0] val;
   } rgb2hsv_stage_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb2hsv_front.sv =====
// Entry stage: finds max and min, the hue sector position and both division
// numerators, and registers them. Depends on rgb2hsv_pkg.
`default_nettype none

module rgb2hsv_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              up_valid,
   output logic                             up_ready,
   input  wire  [7:0]                       red,
   input  wire  [7:0]                       green,
   input  wire  [7:0]                       blue,
   output logic                             down_valid,
   input  wire                              down_ready,
   output rgb2hsv_pkg::rgb2hsv_stage_type   down_data
);
   import rgb2hsv_pkg::*;

   logic [CHANNEL_BITS-1:0] r_w, g_w, b_w;
   logic                    r_top, g_top;
   logic [CHANNEL_BITS-1:0] cmax, cmin, cdif;
   logic [POS_W-1:0]        pos;
   logic [NUM_W-1:0]        hue_num, sat_num;

   logic                    valid_ff;
   rgb2hsv_stage_type       data_ff, data_in;

   // Channel bits above the configured width are ignored.
   assign r_w = red[CHANNEL_BITS-1:0];
   assign g_w = green[CHANNEL_BITS-1:0];
   assign b_w = blue[CHANNEL_BITS-1:0];

   // Largest channel picks the sector; red beats green, green beats blue.
   always_comb begin
      r_top = (r_w >= g_w) && (r_w >= b_w);
      g_top = !r_top && (g_w >= b_w);
      if (r_top) begin
         cmax = r_w;
      end else if (g_top) begin
         cmax = g_w;
      end else begin
         cmax = b_w;
      end
      cmin = r_w;
      if (g_w < cmin) begin
         cmin = g_w;
      end
      if (b_w < cmin) begin
         cmin = b_w;
      end
      cdif = cmax - cmin;
   end

   // Position around the hexcone in units of one sector times cdif.
   always_comb begin
      if (r_top) begin
         pos = POS_W'(6) * POS_W'(cdif) + POS_W'(g_w) - POS_W'(b_w);
      end else if (g_top) begin
         pos = POS_W'(2) * POS_W'(cdif) + POS_W'(b_w) - POS_W'(r_w);
      end else begin
         pos = POS_W'(4) * POS_W'(cdif) + POS_W'(r_w) - POS_W'(g_w);
      end
   end

   // Numerators include half the divisor so that the quotient rounds.
   assign hue_num = NUM_W'(pos) * NUM_W'(HUE_STEP) + NUM_W'(cdif);
   assign sat_num = NUM_W'(cdif) * NUM_W'(SAT_STEP) + NUM_W'(cmax);

   // Preload each division with the numerator bits above the quotient width.
   always_comb begin
      data_in.hue.rem  = hue_num[NUM_W-1:QUO_W];
      data_in.hue.bits = hue_num[QUO_W-1:0];
      data_in.hue.div  = {cdif, 1'b0};
      data_in.sat.rem  = sat_num[NUM_W-1:QUO_W];
      data_in.sat.bits = sat_num[QUO_W-1:0];
      data_in.sat.div  = {cmax, 1'b0};
      data_in.hue_zero = (cdif == '0);
      data_in.sat_zero = (cmax == '0);
      data_in.val      = VAL_W'(cmax);
   end

   // The stage takes a new transfer whenever it is empty or draining.
   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb2hsv_cell.sv =====
// One cell of the divider chain: a single restoring step for both the hue
// and the saturation division, then a register. Depends on rgb2hsv_pkg.
`default_nettype none

module rgb2hsv_cell (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              up_valid,
   output logic                             up_ready,
   input  rgb2hsv_pkg::rgb2hsv_stage_type   up_data,
   output logic                             down_valid,
   input  wire                              down_ready,
   output rgb2hsv_pkg::rgb2hsv_stage_type   down_data
);
   import rgb2hsv_pkg::*;

   logic [DIV_W:0]    hue_shift, sat_shift;
   logic [DIV_W:0]    hue_diff, sat_diff;
   logic              hue_ge, sat_ge;

   logic              valid_ff;
   rgb2hsv_stage_type data_ff, data_in;

   // Bring down the next numerator bit and try to subtract the divisor.
   always_comb begin
      hue_shift = {up_data.hue.rem, up_data.hue.bits[QUO_W-1]};
      sat_shift = {up_data.sat.rem, up_data.sat.bits[QUO_W-1]};
      hue_diff  = hue_shift - {1'b0, up_data.hue.div};
      sat_diff  = sat_shift - {1'b0, up_data.sat.div};
      hue_ge    = hue_shift >= {1'b0, up_data.hue.div};
      sat_ge    = sat_shift >= {1'b0, up_data.sat.div};

      data_in          = up_data;
      data_in.hue.rem  = hue_ge ? hue_diff[DIV_W-1:0] : hue_shift[DIV_W-1:0];
      data_in.sat.rem  = sat_ge ? sat_diff[DIV_W-1:0] : sat_shift[DIV_W-1:0];
      data_in.hue.bits = {up_data.hue.bits[QUO_W-2:0], hue_ge};
      data_in.sat.bits = {up_data.sat.bits[QUO_W-2:0], sat_ge};
   end

   // Bubbles collapse: an empty cell takes a transfer even while stalled.
   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb2hsv_back.sv =====
// Output stage: wraps the hue into one turn, applies the grey and black
// special cases and holds the result register. Depends on rgb2hsv_pkg.
`default_nettype none

module rgb2hsv_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              up_valid,
   output logic                             up_ready,
   input  rgb2hsv_pkg::rgb2hsv_stage_type   up_data,
   output logic                             down_valid,
   input  wire                              down_ready,
   output logic [rgb2hsv_pkg::HUE_W-1:0]    hue,
   output logic [rgb2hsv_pkg::SAT_W-1:0]    sat,
   output logic [rgb2hsv_pkg::VAL_W-1:0]    val
);
   import rgb2hsv_pkg::*;

   logic [QUO_W-1:0] hue_q;
   logic [HUE_W-1:0] hue_in, hue_ff;
   logic [SAT_W-1:0] sat_in, sat_ff;
   logic [VAL_W-1:0] val_ff;
   logic             valid_ff;

   // A rounded hue of a full turn or more folds back by one turn.
   always_comb begin
      hue_q = up_data.hue.bits;
      if (hue_q >= QUO_W'(HUE_FULL)) begin
         hue_q = hue_q - QUO_W'(HUE_FULL);
      end
      hue_in = up_data.hue_zero ? '0 : HUE_W'(hue_q);
      sat_in = up_data.sat_zero ? '0 : up_data.sat.bits[SAT_W-1:0];
   end

   // Result register parts the chain from the receiver.
   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= up_data.val;
      end
   end

   assign down_valid = valid_ff;
   assign hue        = hue_ff;
   assign sat        = sat_ff;
   assign val        = val_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv_converter_unit.sv =====
// RGB to HSV converter, hexcone model: one pixel in, one HSV result out.
// Valid/ready on both channels; a transfer happens when valid and ready
// are both high at a rising clock edge.
// Hue is in sixteenths of a degree (0..5759), saturation is rounded
// 255 * (max - min) / max, and value is the largest channel. Grey and
// black pixels give hue 0 and saturation 0.
// A pixel passes fifteen registers, one entry stage, thirteen divider cells
// (one quotient bit each) and the result register, and the first is loaded
// at the input transfer edge itself. Throughput: one pixel per cycle,
// sustained while rsp_ready stays high, as every stage is registered and
// both divisions advance one bit per cell. When the receiver holds
// rsp_ready low, the result stays in the output register and stages behind
// it keep filling any empty slots, so up to 15 pixels are held before
// req_ready falls.
// Reset (synchronous, active high) empties every stage; no pixel held at
// that moment is delivered.
`default_nettype none
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [7:0]                       req_red_in,
   input  wire  [7:0]                       req_green_in,
   input  wire  [7:0]                       req_blue_in,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [rgb2hsv_pkg::HUE_W-1:0]    rsp_hue_out,
   output logic [rgb2hsv_pkg::SAT_W-1:0]    rsp_sat_out,
   output logic [rgb2hsv_pkg::VAL_W-1:0]    rsp_val_out
);
   import rgb2hsv_pkg::*;

   // Handshake and data along the chain; index 0 is the entry stage.
   logic              chain_valid [CELL_COUNT+1];
   logic              chain_ready [CELL_COUNT+1];
   rgb2hsv_stage_type chain_data  [CELL_COUNT+1];

   // Entry stage.
   rgb2hsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .red        (req_red_in),
      .green      (req_green_in),
      .blue       (req_blue_in),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_data  (chain_data[0])
   );

   // Divider chain, one quotient bit per cell.
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      rgb2hsv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_data    (chain_data[i]),
         .down_valid (chain_valid[i+1]),
         .down_ready (chain_ready[i+1]),
         .down_data  (chain_data[i+1])
      );
   end

   // Result register.
   rgb2hsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[CELL_COUNT]),
      .up_ready   (chain_ready[CELL_COUNT]),
      .up_data    (chain_data[CELL_COUNT]),
      .down_valid (rsp_valid),
      .down_ready (rsp_ready),
      .hue        (rsp_hue_out),
      .sat        (rsp_sat_out),
      .val        (rsp_val_out)
   );

   // Hue always lands inside one turn.
   `RGB2HSV_ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid, rsp_hue_out < HUE_W'(HUE_FULL))
   // A saturated colour cannot come from a black pixel.
   `RGB2HSV_ASSERT_IMPL(a_sat_needs_val, clock, reset, rsp_valid && |rsp_sat_out, |rsp_val_out)
   // Zero saturation only comes from grey, which has hue zero.
   `RGB2HSV_ASSERT_IMPL(a_grey_hue, clock, reset, rsp_valid && ~|rsp_sat_out, ~|rsp_hue_out)
   // With the receiver ready the whole chain moves, so the input is ready too.
   `RGB2HSV_ASSERT_IMPL(a_ready_chain, clock, reset, rsp_ready, req_ready)

endmodule

`default_nettype wire

// ===== dv/rgb_to_hsv_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RGB to HSV converter (hexcone model).
// Needs only the converter RTL and its package; a built-in predictor scores every HSV result.

module rgb_to_hsv_converter_unit_tb;

   // Fixed-point scaling of the conversion: channel full scale, and hue in
   // sixteenths of a degree.
   localparam int CHAN_FULL   = 255;
   localparam int SIXTY_DEG   = 60 * 16;
   localparam int FULL_TURN   = 360 * 16;
   localparam int PIPE_CYCLES = 15;
   localparam int PRINT_LIMIT = 20;

   typedef struct packed {
      logic [rgb2hsv_pkg::HUE_W-1:0] hue;
      logic [rgb2hsv_pkg::SAT_W-1:0] sat;
      logic [rgb2hsv_pkg::VAL_W-1:0] val;
   } hsv_pixel_type;

   // Clock, reset and the block's ports; clock, reset and every input are known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_red_in = 8'd0;
   logic [7:0] req_green_in = 8'd0;
   logic [7:0] req_blue_in = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [rgb2hsv_pkg::HUE_W-1:0] rsp_hue_out;
   logic [rgb2hsv_pkg::SAT_W-1:0] rsp_sat_out;
   logic [rgb2hsv_pkg::VAL_W-1:0] rsp_val_out;

   // Shared state between the stimulus, the receiver and the scoreboard.
   hsv_pixel_type expected_hsv_q[$];
   int mismatch_count = 0;
   int result_count = 0;
   bit idle_enabled = 1'b1;
   int hold_cycles_request = 0;

   rgb_to_hsv_converter_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hue_out(rsp_hue_out),
      .rsp_sat_out(rsp_sat_out),
      .rsp_val_out(rsp_val_out)
   );

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Hexcone conversion of one pixel: value, rounded saturation and
   // rounded hue, with red winning ties over green and green over blue.
   function automatic hsv_pixel_type predict_hsv(input logic [7:0] red,
                                                 input logic [7:0] green,
                                                 input logic [7:0] blue);
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
      logic [31:0] cmax;
      logic [31:0] cmin;
      logic [31:0] cdif;
      logic [31:0] pos;
      logic [31:0] hue_q;
      logic [31:0] sat_q;
      hsv_pixel_type res;
      r = 32'(red);
      g = 32'(green);
      b = 32'(blue);
      cmax = r;
      if (g > cmax) cmax = g;
      if (b > cmax) cmax = b;
      cmin = r;
      if (g < cmin) cmin = g;
      if (b < cmin) cmin = b;
      cdif = cmax - cmin;
      sat_q = 0;
      hue_q = 0;
      if (cmax != 0) sat_q = (2 * cdif * CHAN_FULL + cmax) / (2 * cmax);
      // Sector position scaled by the difference; kept non-negative.
      if (cdif != 0) begin
         if (r == cmax) pos = 6 * cdif + g - b;
         else if (g == cmax) pos = 2 * cdif + b - r;
         else pos = 4 * cdif + r - g;
         hue_q = (2 * pos * SIXTY_DEG + cdif) / (2 * cdif);
         if (hue_q >= FULL_TURN) hue_q = hue_q - FULL_TURN;
      end
      res.hue = hue_q[rgb2hsv_pkg::HUE_W-1:0];
      res.sat = sat_q[rgb2hsv_pkg::SAT_W-1:0];
      res.val = cmax[rgb2hsv_pkg::VAL_W-1:0];
      return res;
   endfunction

   // Prints one line per failure, up to a limit, and counts every one.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Scoreboard: results are compared against the oldest prediction first,
   // then any pixel accepted at this edge is predicted and queued.
   always @(posedge clock) begin : scoreboard
      hsv_pixel_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hsv_q.size() == 0) begin
               report_mismatch("result transfer with no pixel outstanding");
            end else begin
               want = expected_hsv_q.pop_front();
               if (rsp_hue_out !== want.hue)
                  report_mismatch($sformatf("result %0d hue: got %0d, expected %0d",
                                            result_count, rsp_hue_out, want.hue));
               if (rsp_sat_out !== want.sat)
                  report_mismatch($sformatf("result %0d saturation: got %0d, expected %0d",
                                            result_count, rsp_sat_out, want.sat));
               if (rsp_val_out !== want.val)
                  report_mismatch($sformatf("result %0d value: got %0d, expected %0d",
                                            result_count, rsp_val_out, want.val));
            end
            result_count++;
         end
         if (req_valid && req_ready)
            expected_hsv_q.push_back(predict_hsv(req_red_in, req_green_in, req_blue_in));
      end
   end

   // Receiver: ready with random stall bursts, plus long hold-offs on request.
   initial begin : result_receiver
      int n;
      @(negedge clock);
      forever begin
         if (hold_cycles_request > 0) begin
            n = hold_cycles_request;
            hold_cycles_request = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 3);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offers one pixel from a falling edge, optionally after a short gap, and
   // returns at the falling edge after its transfer with valid still high.
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random pixel with a bias towards greys, ties, tiny values and extremes.
   task automatic send_random_pixel();
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] top;
      int mode;
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      mode = $urandom_range(0, 9);
      case (mode)
         0: begin
            g = r;
            b = r;
         end
         1: begin
            // Two channels are set equal to the larger of red and green.
            top = (r > g) ? r : g;
            if ($urandom_range(0, 2) == 0) begin
               r = top;
               g = top;
            end else if ($urandom_range(0, 1) == 0) begin
               g = top;
               b = top;
            end else begin
               r = top;
               b = top;
            end
         end
         2: begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
         end
         3: begin
            r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         default: begin
         end
      endcase
      send_pixel(r, g, b);
   endtask

   // Drops valid and waits until every outstanding pixel has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_hsv_q.size() != 0) @(negedge clock);
   endtask

   // Primaries, secondaries, greys, black and white, tie-breaks, rounding
   // halves and the wrap of a full turn back to zero.
   task automatic test_directed_colours();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd254);
      send_pixel(8'd128, 8'd1, 8'd0);
      send_pixel(8'd2, 8'd1, 8'd1);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd255);
      send_pixel(8'd170, 8'd85, 8'd0);
      send_pixel(8'd85, 8'd170, 8'd255);
      send_pixel(8'd100, 8'd200, 8'd200);
      wait_until_drained();
   endtask

   // Bulk random pixels with idling on both sides.
   task automatic test_random_pixels(input int count);
      repeat (count) send_random_pixel();
   endtask

   // The receiver holds off for a long stretch while pixels keep coming, so
   // the pipeline fills and the input stalls.
   task automatic test_output_backpressure();
      idle_enabled = 1'b0;
      hold_cycles_request = 50;
      repeat (30) send_random_pixel();
      idle_enabled = 1'b1;
   endtask

   // The sender stops until every result is back, then resumes.
   task automatic test_input_pause();
      repeat (10) send_random_pixel();
      wait_until_drained();
      repeat (10) send_random_pixel();
   endtask

   // Final stretch at full rate with no idling anywhere.
   task automatic test_full_rate();
      idle_enabled = 1'b0;
      repeat (40) send_random_pixel();
   endtask

   // Test sequence.
   initial begin : test_sequence
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_colours();
      test_random_pixels(320);
      test_output_backpressure();
      test_input_pause();
      test_full_rate();
      wait_until_drained();
      repeat (PIPE_CYCLES + 5) @(negedge clock);
      if (expected_hsv_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_hsv_q.size()));
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
